### hw/rtl/ascm_pkg.sv
// Shared types, constants and tier tables for the allocation size-class mapper.
`timescale 1ns / 1ps

package ascm_pkg;

   // Field widths of the request and result beats.
   localparam int unsigned REQ_W      = 32;
   localparam int unsigned SIZE_W     = 19;
   localparam int unsigned BUCKET_W   = 8;
   localparam int unsigned BATCH_W    = 10;
   localparam int unsigned PAGES_W    = 7;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned RSP_DATA_W = 48;

   // Divider row: one quotient bit per cell. The quotient only matters below 512.
   localparam int unsigned QUO_BITS = 9;
   localparam int unsigned TRIAL_W  = SIZE_W + QUO_BITS;
   localparam int unsigned PROD_W   = SIZE_W + BATCH_W;

   localparam int unsigned PAGE_BITS = 13;

   localparam logic [SIZE_W-1:0]  MAX_BYTES        = 19'd262144;
   // Sizes at or below this get the full batch without looking at the quotient.
   localparam logic [SIZE_W-1:0]  BATCH_DIRECT_TOP = 19'd512;
   localparam logic [BATCH_W-1:0] BATCH_MIN        = 10'd2;
   localparam logic [BATCH_W-1:0] BATCH_MAX        = 10'd512;

   // First bucket of each tier, from the per-tier class counts.
   localparam logic [BUCKET_W-1:0] CLASSES_TIER0 = 8'd16;
   localparam logic [BUCKET_W-1:0] CLASSES_TIER1 = 8'd56;
   localparam logic [BUCKET_W-1:0] CLASSES_TIER2 = 8'd56;
   localparam logic [BUCKET_W-1:0] CLASSES_TIER3 = 8'd56;
   localparam logic [BUCKET_W-1:0] FIRST_TIER1   = CLASSES_TIER0;
   localparam logic [BUCKET_W-1:0] FIRST_TIER2   = FIRST_TIER1 + CLASSES_TIER1;
   localparam logic [BUCKET_W-1:0] FIRST_TIER3   = FIRST_TIER2 + CLASSES_TIER2;
   localparam logic [BUCKET_W-1:0] FIRST_TIER4   = FIRST_TIER3 + CLASSES_TIER3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ZERO    = 2'd1,
      STATUS_TOO_BIG = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      TIER_8B    = 3'd0,
      TIER_16B   = 3'd1,
      TIER_128B  = 3'd2,
      TIER_1K    = 3'd3,
      TIER_8K    = 3'd4
   } tier_type;

   // What travels with an item down the row of cells.
   typedef struct packed {
      logic [SIZE_W-1:0]   size;
      logic [SIZE_W-1:0]   aligned;
      logic [BUCKET_W-1:0] bucket;
      status_type          status;
   } item_type;

   // Partial remainder and quotient of the batch division.
   typedef struct packed {
      logic [SIZE_W-1:0]   rem;
      logic [QUO_BITS-1:0] quo;
   } div_type;

   // Largest size that falls into a tier.
   function automatic logic [SIZE_W-1:0] tier_top(tier_type t);
      logic [SIZE_W-1:0] top;
      unique case (t)
         TIER_8B:   top = 19'd128;
         TIER_16B:  top = 19'd1024;
         TIER_128B: top = 19'd8192;
         TIER_1K:   top = 19'd65536;
         TIER_8K:   top = MAX_BYTES;
         default:   top = MAX_BYTES;
      endcase
      return top;
   endfunction

   // log2 of the tier alignment.
   function automatic logic [3:0] tier_shift(tier_type t);
      logic [3:0] sh;
      unique case (t)
         TIER_8B:   sh = 4'd3;
         TIER_16B:  sh = 4'd4;
         TIER_128B: sh = 4'd7;
         TIER_1K:   sh = 4'd10;
         TIER_8K:   sh = 4'd13;
         default:   sh = 4'd13;
      endcase
      return sh;
   endfunction

   // Byte size at which a tier starts counting its classes.
   function automatic logic [SIZE_W-1:0] tier_base(tier_type t);
      logic [SIZE_W-1:0] base;
      unique case (t)
         TIER_8B:   base = 19'd0;
         TIER_16B:  base = 19'd128;
         TIER_128B: base = 19'd1024;
         TIER_1K:   base = 19'd8192;
         TIER_8K:   base = 19'd65536;
         default:   base = 19'd65536;
      endcase
      return base;
   endfunction

   function automatic logic [BUCKET_W-1:0] tier_first(tier_type t);
      logic [BUCKET_W-1:0] first;
      unique case (t)
         TIER_8B:   first = '0;
         TIER_16B:  first = FIRST_TIER1;
         TIER_128B: first = FIRST_TIER2;
         TIER_1K:   first = FIRST_TIER3;
         TIER_8K:   first = FIRST_TIER4;
         default:   first = FIRST_TIER4;
      endcase
      return first;
   endfunction

endpackage

### hw/rtl/ascm_front.sv
// Entry cell: status check, tier selection, aligned size and bucket index.
`timescale 1ns / 1ps

module ascm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ascm_pkg::REQ_W-1:0]   in_size,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ascm_pkg::item_type           out_item
);

   logic                                valid_ff;
   logic                                valid_in;
   ascm_pkg::item_type                  item_ff;
   ascm_pkg::item_type                  item_in;
   ascm_pkg::tier_type                  tier;
   logic [ascm_pkg::SIZE_W-1:0]         size;
   logic [ascm_pkg::SIZE_W-1:0]         mask;
   logic [ascm_pkg::SIZE_W-1:0]         aligned;
   logic [ascm_pkg::SIZE_W-1:0]         rel;
   logic [3:0]                          sh;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      size = in_size[ascm_pkg::SIZE_W-1:0];

      priority if (size <= ascm_pkg::tier_top(ascm_pkg::TIER_8B)) begin
         tier = ascm_pkg::TIER_8B;
      end else if (size <= ascm_pkg::tier_top(ascm_pkg::TIER_16B)) begin
         tier = ascm_pkg::TIER_16B;
      end else if (size <= ascm_pkg::tier_top(ascm_pkg::TIER_128B)) begin
         tier = ascm_pkg::TIER_128B;
      end else if (size <= ascm_pkg::tier_top(ascm_pkg::TIER_1K)) begin
         tier = ascm_pkg::TIER_1K;
      end else begin
         tier = ascm_pkg::TIER_8K;
      end

      sh      = ascm_pkg::tier_shift(tier);
      mask    = (ascm_pkg::SIZE_W'(1) << sh) - ascm_pkg::SIZE_W'(1);
      aligned = (size + mask) & ~mask;
      // The tier base is a multiple of the alignment, so the class count
      // within the tier is the aligned offset shifted down.
      rel     = (aligned - ascm_pkg::tier_base(tier)) >> sh;

      item_in.size    = size;
      item_in.aligned = aligned;
      item_in.bucket  = rel[ascm_pkg::BUCKET_W-1:0] + ascm_pkg::tier_first(tier)
                        - ascm_pkg::BUCKET_W'(1);

      priority if (in_size == '0) begin
         item_in.status = ascm_pkg::STATUS_ZERO;
      end else if (in_size > ascm_pkg::REQ_W'(ascm_pkg::MAX_BYTES)) begin
         item_in.status = ascm_pkg::STATUS_TOO_BIG;
      end else begin
         item_in.status = ascm_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### hw/rtl/ascm_div_cell.sv
// One cell of the divider row: settles one quotient bit of the batch division.
`timescale 1ns / 1ps

module ascm_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ascm_pkg::item_type  in_item,
   input  ascm_pkg::div_type   in_div,
   output logic                out_valid,
   input  logic                out_ready,
   output ascm_pkg::item_type  out_item,
   output ascm_pkg::div_type   out_div
);

   logic                                valid_ff;
   logic                                valid_in;
   ascm_pkg::item_type                  item_ff;
   ascm_pkg::div_type                   div_ff;
   ascm_pkg::div_type                   div_in;
   logic [ascm_pkg::TRIAL_W-1:0]        trial;
   logic [ascm_pkg::TRIAL_W-1:0]        rem_wide;
   logic                                take;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Restoring step: subtract the shifted divisor when it fits.
   always_comb begin
      trial    = ascm_pkg::TRIAL_W'(in_item.size) << BIT;
      rem_wide = ascm_pkg::TRIAL_W'(in_div.rem);
      take     = rem_wide >= trial;
      div_in   = in_div;
      if (take) begin
         div_in.rem = ascm_pkg::SIZE_W'(rem_wide - trial);
      end
      div_in.quo[BIT] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_div   = div_ff;

endmodule

### hw/rtl/ascm_span.sv
// Tail cells: batch clamp and multiply, then span pages and the result register.
`timescale 1ns / 1ps

module ascm_span (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  ascm_pkg::item_type                in_item,
   input  logic [ascm_pkg::QUO_BITS-1:0]     in_quo,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [ascm_pkg::SIZE_W-1:0]       out_aligned,
   output logic [ascm_pkg::BUCKET_W-1:0]     out_bucket,
   output logic [ascm_pkg::BATCH_W-1:0]      out_batch,
   output logic [ascm_pkg::PAGES_W-1:0]      out_pages,
   output ascm_pkg::status_type              out_status
);

   // Multiply stage.
   logic                                mul_valid_ff;
   logic                                mul_valid_in;
   logic                                mul_ready;
   ascm_pkg::item_type                  mul_item_ff;
   logic [ascm_pkg::BATCH_W-1:0]        batch_ff;
   logic [ascm_pkg::BATCH_W-1:0]        batch_in;
   logic [ascm_pkg::PROD_W-1:0]         prod_ff;
   logic [ascm_pkg::PROD_W-1:0]         prod_in;

   // Result stage.
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic                                rsp_ready;
   logic [ascm_pkg::SIZE_W-1:0]         aligned_ff;
   logic [ascm_pkg::BUCKET_W-1:0]       bucket_ff;
   logic [ascm_pkg::BATCH_W-1:0]        rsp_batch_ff;
   logic [ascm_pkg::PAGES_W-1:0]        pages_ff;
   logic [ascm_pkg::PAGES_W-1:0]        pages_in;
   ascm_pkg::status_type                status_ff;
   logic [ascm_pkg::PROD_W-1:0]         pages_full;
   logic                                ok;

   assign rsp_ready    = !rsp_valid_ff || out_ready;
   assign mul_ready    = !mul_valid_ff || rsp_ready;
   assign in_ready     = mul_ready;
   assign mul_valid_in = mul_ready ? in_valid : mul_valid_ff;
   assign rsp_valid_in = rsp_ready ? mul_valid_ff : rsp_valid_ff;

   // Small sizes overflow the quotient row but always take the full batch.
   always_comb begin
      priority if (in_item.size <= ascm_pkg::BATCH_DIRECT_TOP) begin
         batch_in = ascm_pkg::BATCH_MAX;
      end else if (ascm_pkg::BATCH_W'(in_quo) < ascm_pkg::BATCH_MIN) begin
         batch_in = ascm_pkg::BATCH_MIN;
      end else begin
         batch_in = ascm_pkg::BATCH_W'(in_quo);
      end
      prod_in = ascm_pkg::PROD_W'(batch_in) * ascm_pkg::PROD_W'(in_item.size);
   end

   always_comb begin
      pages_full = prod_ff >> ascm_pkg::PAGE_BITS;
      ok         = mul_item_ff.status == ascm_pkg::STATUS_OK;
      if (pages_full == '0) begin
         pages_in = ascm_pkg::PAGES_W'(1);
      end else begin
         pages_in = pages_full[ascm_pkg::PAGES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && mul_ready) begin
         mul_item_ff <= in_item;
         batch_ff    <= batch_in;
         prod_ff     <= prod_in;
      end
   end

   // Errors report zeros in every field but the status.
   always_ff @(posedge clock) begin
      if (mul_valid_ff && rsp_ready) begin
         aligned_ff   <= ok ? mul_item_ff.aligned : '0;
         bucket_ff    <= ok ? mul_item_ff.bucket : '0;
         rsp_batch_ff <= ok ? batch_ff : '0;
         pages_ff     <= ok ? pages_in : '0;
         status_ff    <= mul_item_ff.status;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_aligned = aligned_ff;
   assign out_bucket  = bucket_ff;
   assign out_batch   = rsp_batch_ff;
   assign out_pages   = pages_ff;
   assign out_status  = status_ff;

endmodule

### hw/rtl/alloc_size_class_mapper_unit.sv
// Top level of the allocation size-class mapper: entry cell, divider row, span cells.
`timescale 1ns / 1ps

// Maps one allocation request size per beat to its size class: the size rounded
// up to its tier alignment, the free-list bucket (0 to 207), the refill batch
// count (256K divided by the request size, clamped to 2..512) and the pages per
// span (batch times size over the 8K page, at least 1). A size of zero or above
// 256K returns status 1 or 2 with the other fields zero. The block is a row of
// cells that each hold one item and hand it on every cycle while the next cell
// can take it: one entry cell for the status, tier, alignment and bucket, nine
// divider cells that each settle one quotient bit of the batch division, a cell
// that clamps the batch and multiplies it by the size, and the result register
// that forms the page count. An item passes through these registers in that
// order on its way to the result beat, and a new request beat is taken in every
// cycle while results are taken as fast. When the result side stalls, the row
// keeps filling its empty cells, so requests are still taken until every cell
// holds an item. Reset only empties the cells; no clearing pass is needed.
module alloc_size_class_mapper_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request beat.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ascm_pkg::REQ_W-1:0]           req_tdata,   // [31:0] request_size
   // Result beat.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ascm_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [18:0] aligned_size,
                                                             // [26:19] bucket_index,
                                                             // [36:27] batch_count,
                                                             // [43:37] span_pages,
                                                             // [47:44] zero
   output logic [ascm_pkg::STATUS_W-1:0]        rsp_tuser    // [1:0] status
);

   localparam int unsigned PAD_W = ascm_pkg::RSP_DATA_W - ascm_pkg::SIZE_W
                                   - ascm_pkg::BUCKET_W - ascm_pkg::BATCH_W
                                   - ascm_pkg::PAGES_W;

   // Link k feeds divider cell k; link 0 comes from the entry cell.
   logic                   link_valid [ascm_pkg::QUO_BITS+1];
   logic                   link_ready [ascm_pkg::QUO_BITS+1];
   ascm_pkg::item_type     link_item  [ascm_pkg::QUO_BITS+1];
   ascm_pkg::div_type      link_div   [ascm_pkg::QUO_BITS+1];

   logic [ascm_pkg::SIZE_W-1:0]     rsp_aligned;
   logic [ascm_pkg::BUCKET_W-1:0]   rsp_bucket;
   logic [ascm_pkg::BATCH_W-1:0]    rsp_batch;
   logic [ascm_pkg::PAGES_W-1:0]    rsp_pages;
   ascm_pkg::status_type            rsp_status;

   ascm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_size   (req_tdata),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_item  (link_item[0])
   );

   // The division starts from the full 256K dividend with an empty quotient.
   assign link_div[0].rem = ascm_pkg::MAX_BYTES;
   assign link_div[0].quo = '0;

   for (genvar k = 0; k < ascm_pkg::QUO_BITS; k++) begin : g_div
      ascm_div_cell #(
         .BIT (ascm_pkg::QUO_BITS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_item   (link_item[k]),
         .in_div    (link_div[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_item  (link_item[k+1]),
         .out_div   (link_div[k+1])
      );
   end

   ascm_span u_span (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[ascm_pkg::QUO_BITS]),
      .in_ready    (link_ready[ascm_pkg::QUO_BITS]),
      .in_item     (link_item[ascm_pkg::QUO_BITS]),
      .in_quo      (link_div[ascm_pkg::QUO_BITS].quo),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_aligned (rsp_aligned),
      .out_bucket  (rsp_bucket),
      .out_batch   (rsp_batch),
      .out_pages   (rsp_pages),
      .out_status  (rsp_status)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_pages, rsp_batch, rsp_bucket, rsp_aligned};
   assign rsp_tuser = rsp_status;

endmodule

### hw/rtl/ascm_checker.sv
// Port-level checks on the size-class mapper and their binding to the top level.
`timescale 1ns / 1ps

module ascm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [ascm_pkg::REQ_W-1:0]           req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [ascm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic [ascm_pkg::STATUS_W-1:0]        rsp_tuser
);

   logic [ascm_pkg::BUCKET_W-1:0]   bucket;
   logic [ascm_pkg::BATCH_W-1:0]    batch;
   logic [ascm_pkg::PAGES_W-1:0]    pages;
   logic                            req_seen;

   assign bucket   = rsp_tdata[26:19];
   assign batch    = rsp_tdata[36:27];
   assign pages    = rsp_tdata[43:37];
   assign req_seen = req_tvalid && req_tready && (req_tdata != '0);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // No result beat right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // An error result carries zeros in all data fields.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ascm_pkg::STATUS_OK) |-> rsp_tdata == '0)
      else $error("error result with nonzero fields");

   // A good result has a batch within its clamp, a page count and a valid bucket.
   a_ok_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ascm_pkg::STATUS_OK) |->
         batch >= ascm_pkg::BATCH_MIN && batch <= ascm_pkg::BATCH_MAX &&
         pages != '0 && bucket <= ascm_pkg::BUCKET_W'(207))
      else $error("good result out of range");

   // The status code is one of the three defined outcomes, unless a nonzero request is taken in the same cycle.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ascm_pkg::STATUS_OK || rsp_tuser == ascm_pkg::STATUS_ZERO ||
                     rsp_tuser == ascm_pkg::STATUS_TOO_BIG || req_seen)
      else $error("undefined status code");

endmodule

bind alloc_size_class_mapper_unit ascm_checker u_checker (.*);

### tb/alloc_size_class_mapper_unit_tb.sv
// Self-checking testbench for the allocation size-class mapper: directed and random sizes.
`timescale 1ns / 1ps

// Request sizes are driven as beats on the req_ channel. Each accepted size is
// mapped to its expected size class by a predictor kept in this file. Each result
// beat on the rsp_ channel is compared field by field with the oldest
// expectation. The run has these phases:
//   1. A directed table of tier edges, clamp edges and both error cases. Rows
//      whose result is obvious carry it typed in, and the rest use the predictor.
//   2. Random sizes, with both sides idling at random.
//   3. A stretch with no idling on either side.
//   4. A burst sent while the receiver holds off for a long time. The cell row
//      fills up and the request side stalls.
//   5. More random sizes.
// The sender waits for every expected result to come back after the directed
// table, again after the burst and once more at the end.
module alloc_size_class_mapper_unit_tb;

   localparam int unsigned ALIGNED_LSB  = 0;
   localparam int unsigned BUCKET_LSB   = ALIGNED_LSB + ascm_pkg::SIZE_W;
   localparam int unsigned BATCH_LSB    = BUCKET_LSB + ascm_pkg::BUCKET_W;
   localparam int unsigned PAGES_LSB    = BATCH_LSB + ascm_pkg::BATCH_W;
   localparam int unsigned PAD_LSB      = PAGES_LSB + ascm_pkg::PAGES_W;
   localparam int unsigned PAD_W        = ascm_pkg::RSP_DATA_W - PAD_LSB;

   // The run goes on for TAIL_CYCLES after the last result so that any stray beat
   // is still seen.
   localparam int unsigned TAIL_CYCLES  = 24;
   localparam int unsigned HOLD_CYCLES  = 100;
   // The slowest correct run goes longest without a beat during the long hold of the
   // receiver. This limit is many times HOLD_CYCLES.
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned IDLE_PERCENT = 32;

   // One result beat, unpacked into its fields.
   typedef struct packed {
      logic [ascm_pkg::SIZE_W-1:0]   aligned;
      logic [ascm_pkg::BUCKET_W-1:0] bucket;
      logic [ascm_pkg::BATCH_W-1:0]  batch;
      logic [ascm_pkg::PAGES_W-1:0]  pages;
      ascm_pkg::status_type          status;
   } size_class_type;

   // One directed row. When known is set, the typed result is used in place of
   // the predictor.
   typedef struct packed {
      logic [ascm_pkg::REQ_W-1:0] size;
      logic                       known;
      size_class_type             result;
   } directed_row_type;

   localparam int unsigned DIRECTED_N = 23;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{32'd0,         1'b1, '{19'd0,      8'd0,   10'd0,   7'd0,  ascm_pkg::STATUS_ZERO}},
      '{32'd1,         1'b1, '{19'd8,      8'd0,   10'd512, 7'd1,  ascm_pkg::STATUS_OK}},
      '{32'd8,         1'b0, '0},
      '{32'd9,         1'b0, '0},
      '{32'd120,       1'b0, '0},
      '{32'd128,       1'b0, '0},
      '{32'd129,       1'b0, '0},
      '{32'd512,       1'b0, '0},
      '{32'd513,       1'b0, '0},
      '{32'd1024,      1'b0, '0},
      '{32'd1025,      1'b0, '0},
      '{32'd5000,      1'b0, '0},
      '{32'd8192,      1'b0, '0},
      '{32'd8193,      1'b0, '0},
      '{32'd65536,     1'b0, '0},
      '{32'd65537,     1'b0, '0},
      '{32'd131072,    1'b0, '0},
      '{32'd131073,    1'b0, '0},
      '{32'd262143,    1'b0, '0},
      '{32'd262144,    1'b1, '{19'd262144, 8'd207, 10'd2,   7'd64, ascm_pkg::STATUS_OK}},
      '{32'd262145,    1'b1, '{19'd0,      8'd0,   10'd0,   7'd0,  ascm_pkg::STATUS_TOO_BIG}},
      '{32'h8000_0000, 1'b1, '{19'd0,      8'd0,   10'd0,   7'd0,  ascm_pkg::STATUS_TOO_BIG}},
      '{32'hFFFF_FFFF, 1'b1, '{19'd0,      8'd0,   10'd0,   7'd0,  ascm_pkg::STATUS_TOO_BIG}}
   };

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [ascm_pkg::REQ_W-1:0]          req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ascm_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [ascm_pkg::STATUS_W-1:0]       rsp_tuser;

   // Results of sizes that are offered but not yet taken, then results of sizes
   // that are taken but whose result beat has not yet come.
   size_class_type offered_class_q[$];
   size_class_type class_expect_q[$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   bit          no_idle        = 1'b0;
   int unsigned hold_tickets   = 0;
   int unsigned holds_served   = 0;
   int unsigned hold_left      = 0;

   alloc_size_class_mapper_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Computes the size class of a request size. The tier is chosen on the raw
   // size, and so are the batch and the page count, never the aligned size.
   function automatic size_class_type map_size_class(logic [ascm_pkg::REQ_W-1:0] req_size);
      size_class_type res;
      logic [63:0] sz;
      logic [63:0] unit;
      logic [63:0] base;
      logic [63:0] first;
      logic [63:0] batch;
      logic [63:0] pages;
      int unsigned sh;
      res = '0;
      sz  = 64'(req_size);
      if (sz == 0) begin
         res.status = ascm_pkg::STATUS_ZERO;
      end else if (sz > 64'd262144) begin
         res.status = ascm_pkg::STATUS_TOO_BIG;
      end else begin
         if (sz <= 64'd128) begin
            sh = 3;  base = 64'd0;     first = 64'd0;
         end else if (sz <= 64'd1024) begin
            sh = 4;  base = 64'd128;   first = 64'd16;
         end else if (sz <= 64'd8192) begin
            sh = 7;  base = 64'd1024;  first = 64'd72;
         end else if (sz <= 64'd65536) begin
            sh = 10; base = 64'd8192;  first = 64'd128;
         end else begin
            sh = 13; base = 64'd65536; first = 64'd184;
         end
         unit        = 64'd1 << sh;
         res.aligned = ascm_pkg::SIZE_W'((sz + unit - 1) & ~(unit - 1));
         res.bucket  = ascm_pkg::BUCKET_W'((((sz - base) + unit - 1) >> sh) - 1 + first);
         batch = 64'd262144 / sz;
         if (batch < 64'd2) begin
            batch = 64'd2;
         end
         if (batch > 64'd512) begin
            batch = 64'd512;
         end
         pages = (batch * sz) >> ascm_pkg::PAGE_BITS;
         if (pages < 64'd1) begin
            pages = 64'd1;
         end
         res.batch  = ascm_pkg::BATCH_W'(batch);
         res.pages  = ascm_pkg::PAGES_W'(pages);
         res.status = ascm_pkg::STATUS_OK;
      end
      return res;
   endfunction

   // Most random sizes are valid and spread evenly over the five tiers. The rest
   // sit next to tier and clamp edges, are zero, or are fully random 32-bit
   // words. Those are mostly too big, and they toggle every bit of the field.
   function automatic logic [ascm_pkg::REQ_W-1:0] pick_size();
      int unsigned edge_sizes [9] = '{64, 128, 256, 512, 1024, 8192, 65536, 131072,
                                     262144};
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 2) begin
         return '0;
      end else if (roll < 12) begin
         return $urandom;
      end else if (roll < 24) begin
         return edge_sizes[$urandom_range(8)] + $urandom_range(2) - 1;
      end else begin
         case ($urandom_range(4))
            0:       return $urandom_range(128, 1);
            1:       return $urandom_range(1024, 129);
            2:       return $urandom_range(8192, 1025);
            3:       return $urandom_range(65536, 8193);
            default: return $urandom_range(262144, 65537);
         endcase
      end
   endfunction

   // Offers one size and returns once the block has taken it. Idle cycles are
   // inserted before the beat unless idling is switched off.
   task automatic offer_size(input logic [ascm_pkg::REQ_W-1:0] req_size,
                             input size_class_type want);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      offered_class_q.push_back(want);
      req_tdata  <= req_size;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_random(input int unsigned count);
      logic [ascm_pkg::REQ_W-1:0] req_size;
      repeat (count) begin
         req_size = pick_size();
         offer_size(req_size, map_size_class(req_size));
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (offered_class_q.size() != 0 || class_expect_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // The receiver stalls at random, except during the stretch with no idling. It
   // holds off for HOLD_CYCLES, counted here, each time a hold is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_tickets) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_tready   <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Moves the expectation of a taken size into the store of pending results,
   // and checks each result beat against the oldest pending result.
   always @(posedge clock) begin
      size_class_type got;
      size_class_type want;
      if (!reset) begin
         if (req_tvalid && req_tready && offered_class_q.size() != 0) begin
            class_expect_q.push_back(offered_class_q[0]);
            offered_class_q.delete(0);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.aligned = rsp_tdata[ALIGNED_LSB +: ascm_pkg::SIZE_W];
            got.bucket  = rsp_tdata[BUCKET_LSB +: ascm_pkg::BUCKET_W];
            got.batch   = rsp_tdata[BATCH_LSB +: ascm_pkg::BATCH_W];
            got.pages   = rsp_tdata[PAGES_LSB +: ascm_pkg::PAGES_W];
            got.status  = ascm_pkg::status_type'(rsp_tuser);
            if (class_expect_q.size() == 0) begin
               $error("result beat with no request pending");
               mismatch_count++;
            end else begin
               want = class_expect_q[0];
               class_expect_q.delete(0);
               compare_field("aligned_size", 32'(want.aligned), 32'(got.aligned));
               compare_field("bucket_index", 32'(want.bucket), 32'(got.bucket));
               compare_field("batch_count", 32'(want.batch), 32'(got.batch));
               compare_field("span_pages", 32'(want.pages), 32'(got.pages));
               compare_field("status", 32'(want.status), 32'(got.status));
               compare_field("tdata_pad", 32'd0, 32'(rsp_tdata[PAD_LSB +: PAD_W]));
            end
         end
      end
   end

   // Ends the run when no beat has moved on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("alloc_size_class_mapper_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: tier edges, clamp edges of the batch, and both errors.
      for (int unsigned i = 0; i < DIRECTED_N; i++) begin
         offer_size(DIRECTED_ROWS[i].size,
                    DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].result
                                           : map_size_class(DIRECTED_ROWS[i].size));
      end
      wait_for_results();

      offer_random(450);

      // Back-to-back beats on both sides.
      no_idle = 1'b1;
      offer_random(300);

      // Keep sending while the receiver holds off, so that the row fills up and
      // the request side stalls. Then let everything drain.
      hold_tickets++;
      offer_random(200);
      no_idle = 1'b0;
      wait_for_results();

      offer_random(450);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("alloc_size_class_mapper_unit: match");
      end else begin
         $display("alloc_size_class_mapper_unit: mismatch");
      end
      $finish;
   end

endmodule

### alloc_size_class_mapper_unit.f
hw/rtl/ascm_pkg.sv
hw/rtl/ascm_front.sv
hw/rtl/ascm_div_cell.sv
hw/rtl/ascm_span.sv
hw/rtl/alloc_size_class_mapper_unit.sv
hw/rtl/ascm_checker.sv
tb/alloc_size_class_mapper_unit_tb.sv
